/* rtl/core/bpfe_pkg.sv */
// ----------------------------------------------------------------------------
// bpfe_pkg
// shared types of the ber primitive field encoder: the job that the front
// hands to the back through the job queue
// ----------------------------------------------------------------------------
package bpfe_pkg;

	// a job holds up to eight encoded bytes, first transmitted at index 0
	localparam int JOB_BYTES = 8;
	localparam int IDX_W     = $clog2(JOB_BYTES);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
	} job_t;

endpackage

/* rtl/core/bpfe_front.sv */
// ----------------------------------------------------------------------------
// bpfe_front
// classifies one input item and builds the full byte list of its encoding
// ----------------------------------------------------------------------------
module bpfe_front (
	input  logic               [2:0]  action,
	input  logic               [1:0]  tag_class,
	input  logic                      constructed,
	input  logic               [31:0] uvalue,
	input  logic signed        [63:0] signed_value,
	output bpfe_pkg::job_t            job,
	output logic                      job_ok
);

	typedef enum logic [2:0] {
		ACT_IDENT   = 3'd0,
		ACT_LENGTH  = 3'd1,
		ACT_INTEGER = 3'd2,
		ACT_BOOLEAN = 3'd3,
		ACT_SUBID   = 3'd4
	} action_t;

	typedef struct packed {
		logic [4:0][7:0] bytes;
		logic [2:0]      count;
	} b128_t;

	localparam logic [7:0]  TAG_LONG      = 8'h1f;
	localparam logic [7:0]  LEN_LONG      = 8'h80;
	localparam logic [7:0]  BOOL_TRUE     = 8'hff;
	localparam logic [31:0] SHORT_TAG_MAX = 32'd30;
	localparam logic [31:0] SHORT_LEN_MAX = 32'h7f;

	// base-128 groups, most significant first, continuation bit on all but last
	function automatic b128_t base128(input logic [31:0] v);
		b128_t       r;
		logic [2:0]  g;
		logic [31:0] sh;
		int          k;
		if (v <= 32'h7f) g = 3'd1;
		else if (v <= 32'h3fff) g = 3'd2;
		else if (v <= 32'h1f_ffff) g = 3'd3;
		else if (v <= 32'hfff_ffff) g = 3'd4;
		else g = 3'd5;
		r.count = g;
		r.bytes = '0;
		for (k = 0; k < 5; k++) begin
			if (3'(k) < g) begin
				sh = v >> (7 * (int'(g) - 1 - k));
				r.bytes[k] = {(3'(k) != (g - 3'd1)), sh[6:0]};
			end
		end
		return r;
	endfunction

	b128_t             b;
	logic [7:0]        octet0;
	logic [2:0]        nlen;
	logic [3:0]        ilen;
	logic signed [63:0] t;
	logic [63:0]       sh64;
	logic [31:0]       sh32;
	int                k;
	int                n;

	assign octet0 = {tag_class, constructed, 5'b0};
	assign b      = base128(uvalue);

	always_comb begin
		job    = '0;
		job_ok = 1'b1;
		nlen   = 3'd2;
		ilen   = 4'd8;
		t      = '0;
		sh64   = '0;
		sh32   = '0;
		case (action_t'(action))
			ACT_IDENT: begin
				if (uvalue <= SHORT_TAG_MAX) begin
					job.bytes[0] = octet0 | {3'b0, uvalue[4:0]};
					job.last_idx = '0;
				end else begin
					job.bytes[0] = octet0 | TAG_LONG;
					for (k = 0; k < 5; k++) job.bytes[k+1] = b.bytes[k];
					job.last_idx = b.count;
				end
			end
			ACT_LENGTH: begin
				if (uvalue <= SHORT_LEN_MAX) begin
					job.bytes[0] = uvalue[7:0];
					job.last_idx = '0;
				end else begin
					// lengths up to 0xffff always use two length bytes
					if (uvalue <= 32'hffff) nlen = 3'd2;
					else if (uvalue <= 32'hff_ffff) nlen = 3'd3;
					else nlen = 3'd4;
					job.bytes[0] = LEN_LONG | {5'b0, nlen};
					for (k = 0; k < 4; k++) begin
						if (3'(k) < nlen) begin
							sh32 = uvalue >> (8 * (int'(nlen) - 1 - k));
							job.bytes[k+1] = sh32[7:0];
						end
					end
					job.last_idx = nlen;
				end
			end
			ACT_INTEGER: begin
				// shortest two's complement form whose sign matches
				for (n = 7; n >= 1; n--) begin
					t = signed_value >>> (8 * n - 1);
					if ((t == '0) || (t == '1)) ilen = 4'(n);
				end
				for (k = 0; k < 8; k++) begin
					if (4'(k) < ilen) begin
						sh64 = signed_value >> (8 * (int'(ilen) - 1 - k));
						job.bytes[k] = sh64[7:0];
					end
				end
				job.last_idx = 3'(ilen - 4'd1);
			end
			ACT_BOOLEAN: begin
				job.bytes[0] = (signed_value != '0) ? BOOL_TRUE : 8'h00;
				job.last_idx = '0;
			end
			ACT_SUBID: begin
				for (k = 0; k < 5; k++) job.bytes[k] = b.bytes[k];
				job.last_idx = b.count - 3'd1;
			end
			default: job_ok = 1'b0;
		endcase
	end

endmodule

/* rtl/core/bpfe_fifo.sv */
// ----------------------------------------------------------------------------
// bpfe_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module bpfe_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpfe_pkg::job_t wdata,
	input  logic           pop,
	output bpfe_pkg::job_t rdata,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bpfe_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop) rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue count beyond depth");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("job queue count lost a pop");

endmodule

/* rtl/core/bpfe_back.sv */
// ----------------------------------------------------------------------------
// bpfe_back
// takes jobs from the queue and sends their bytes one per cycle through an
// output register, holding while out_pop is low and the output is full
// ----------------------------------------------------------------------------
module bpfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  bpfe_pkg::job_t job,
	input  logic           job_avail,
	output logic           job_take,
	input  logic           out_pop,
	output logic           out_valid,
	output logic [7:0]     out_byte,
	output logic           last
);

	bpfe_pkg::job_t                cur_q;
	logic [bpfe_pkg::IDX_W-1:0]    idx_q;
	logic                          busy_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          last_q;
	logic                          adv;
	logic                          at_end;

	assign adv      = !out_valid_q || out_pop;
	assign at_end   = (idx_q == cur_q.last_idx);
	// load a new job when idle, or as the last byte of the current one leaves
	assign job_take = job_avail && (!busy_q || (adv && at_end));

	always_ff @(posedge clk) begin
		if (job_take) cur_q <= job;
		if (adv && busy_q) begin
			out_byte_q <= cur_q.bytes[idx_q];
			last_q     <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) out_valid_q <= busy_q;
			if (job_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (adv && busy_q) begin
				if (at_end) busy_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= cur_q.last_idx))
		else $error("byte index past end of job");

	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_avail)
		else $error("job taken from empty queue");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && at_end && !job_take) |=> !busy_q)
		else $error("back stayed busy after last byte");

	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && at_end) |=> (out_valid_q && last_q))
		else $error("final byte not marked");

endmodule

/* rtl/core/ber_primitive_field_encoder_top.sv */
// ----------------------------------------------------------------------------
// ber_primitive_field_encoder_top
// asn.1 ber primitive field encoder: identifier, definite length, integer,
// boolean and oid subidentifier fields, one encoded byte per result beat
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: a beat is taken at a clock edge with
//   push high and full low. action selects the field kind; action codes
//   5 to 7 are taken and dropped with no output.
//   output side is a queue read port: while empty is low, out_byte and last
//   hold the oldest byte; it leaves at an edge with pop high.
//   last marks the final byte of one item's encoding.
// timing
//   front builds the whole byte list in the cycle of acceptance and writes
//   it into a job queue of QUEUE_DEPTH entries; when the queue and output
//   are idle, the first byte goes from the queue through the back's job
//   register into the output register. the back sends one byte per cycle
//   while pop allows it; an item has 1 to 8 bytes. the byte serializer sets
//   the sustained rate, jobs follow each other with no gap.
// reset and stall
//   arst_n clears the queue, the serializer and the output register.
//   when pop stays low the output byte holds, the serializer stops, the
//   queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module ber_primitive_field_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic        [2:0]  action,
	input  logic        [1:0]  tag_class,
	input  logic               constructed,
	input  logic        [31:0] uvalue,
	input  logic signed [63:0] signed_value,
	output logic               empty,
	input  logic               pop,
	output logic        [7:0]  out_byte,
	output logic               last
);

	bpfe_pkg::job_t front_job;
	bpfe_pkg::job_t queue_job;
	logic           front_ok;
	logic           queue_empty;
	logic           queue_take;
	logic           out_valid;

	// front: classify and build the byte list
	bpfe_front u_front (
		.action         (action),
		.tag_class      (tag_class),
		.constructed    (constructed),
		.uvalue         (uvalue),
		.signed_value   (signed_value),
		.job            (front_job),
		.job_ok         (front_ok)
	);

	// job queue; unused action codes never enter it
	bpfe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && front_ok),
		.wdata  (front_job),
		.pop    (queue_take),
		.rdata  (queue_job),
		.full   (full),
		.empty  (queue_empty)
	);

	// back: serializer with output register
	bpfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_avail (!queue_empty),
		.job_take  (queue_take),
		.out_pop   (pop),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last)
	);

	assign empty = !out_valid;

endmodule

/* bench/tb_ber_primitive_field_encoder_top.sv */
// ----------------------------------------------------------------------------
// tb_ber_primitive_field_encoder_top
// self-checking bench for the ber primitive field encoder: a short table of
// hand-picked fields (extremes of every encoding, dropped action codes) is
// followed by randomized fields of all five kinds. every accepted input beat
// owes either its typed-in bytes or those of a local byte-list model, and each
// output byte is compared against the oldest expected byte, with random gaps
// on push and pop
module tb_ber_primitive_field_encoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	// action codes
	localparam logic [2:0] ACT_IDENT   = 3'd0;
	localparam logic [2:0] ACT_LENGTH  = 3'd1;
	localparam logic [2:0] ACT_INTEGER = 3'd2;
	localparam logic [2:0] ACT_BOOLEAN = 3'd3;
	localparam logic [2:0] ACT_SUBID   = 3'd4;
	localparam logic [2:0] ACT_RSVD5   = 3'd5;
	localparam logic [2:0] ACT_RSVD7   = 3'd7;

	// tag classes
	localparam logic [1:0] CLS_UNIVERSAL   = 2'd0;
	localparam logic [1:0] CLS_APPLICATION = 2'd1;
	localparam logic [1:0] CLS_CONTEXT     = 2'd2;
	localparam logic [1:0] CLS_PRIVATE     = 2'd3;

	localparam int RANDOM_FIELDS = 440;
	localparam int PAUSE_AT      = 220;
	localparam int MAX_REPORTS   = 10;

	// one expected output beat
	typedef struct {
		logic [7:0] octet;
		logic       fin;
	} octet_beat_t;

	// one row of the directed table; when given is set, the expected bytes
	// are typed in: count bytes right-justified in octets, first sent on top
	typedef struct {
		logic [2:0]         act;
		logic [1:0]         cls;
		logic               cons;
		logic [31:0]        uval;
		logic signed [63:0] sval;
		bit                 given;
		int                 count;
		logic [63:0]        octets;
	} stim_row_t;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               push           = 1'b0;
	logic               full;
	logic        [2:0]  action         = ACT_IDENT;
	logic        [1:0]  tag_class      = CLS_UNIVERSAL;
	logic               constructed    = 1'b0;
	logic        [31:0] uvalue         = '0;
	logic signed [63:0] signed_value   = '0;
	logic               empty;
	logic               pop            = 1'b0;
	logic        [7:0]  out_byte;
	logic               last;

	ber_primitive_field_encoder_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.tag_class     (tag_class),
		.constructed   (constructed),
		.uvalue        (uvalue),
		.signed_value  (signed_value),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last          (last)
	);

	// bytes still owed by the block, oldest first
	octet_beat_t pending_octets[$];

	// typed expectation that goes with the beat being offered
	bit          row_given;
	int          row_count;
	logic [63:0] row_octets;

	// bookkeeping
	int  fail_count     = 0;
	int  octets_checked = 0;
	int  fields_by_kind[5] = '{0, 0, 0, 0, 0};
	int  dropped_codes  = 0;
	bit  no_idle        = 1'b0;
	int  pop_stall      = 0;

	stim_row_t directed_rows [0:24] = '{
		// identifier: short form extremes, first long tag, widest long tag
		'{ACT_IDENT,   CLS_UNIVERSAL,   1'b0, 32'd0,          64'sd0,  1'b1, 1, 64'h00},
		'{ACT_IDENT,   CLS_PRIVATE,     1'b1, 32'd30,         64'sd0,  1'b1, 1, 64'hfe},
		'{ACT_IDENT,   CLS_APPLICATION, 1'b0, 32'd31,         -64'sd1, 1'b1, 2, 64'h5f1f},
		'{ACT_IDENT,   CLS_CONTEXT,     1'b1, 32'hffff_ffff,  64'sd0,  1'b1, 6,
			64'hbf_8f_ff_ff_ff_7f},
		'{ACT_IDENT,   CLS_UNIVERSAL,   1'b1, 32'h3fff,       64'sh5a5a_a5a5_0f0f_f0f0,
			1'b0, 0, 64'h0},
		// definite length: short form ends, each long form boundary
		'{ACT_LENGTH,  CLS_PRIVATE,     1'b1, 32'd0,          64'sd0,  1'b1, 1, 64'h00},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'd127,        64'sd0,  1'b1, 1, 64'h7f},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'd128,        64'sd0,  1'b1, 3, 64'h82_0080},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'hffff,       64'sd0,  1'b1, 3, 64'h82_ffff},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'h1_0000,     64'sd0,  1'b1, 4,
			64'h83_01_0000},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'h100_0000,   64'sd0,  1'b1, 5,
			64'h84_0100_0000},
		'{ACT_LENGTH,  CLS_UNIVERSAL,   1'b0, 32'hffff_ffff,  64'sd0,  1'b1, 5,
			64'h84_ffff_ffff},
		// integer: zero, minus one, sign-pad cases, widest values
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'd0,          64'sd0,  1'b1, 1, 64'h00},
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'hffff_ffff,  -64'sd1, 1'b1, 1, 64'hff},
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'd0,          64'sd128, 1'b1, 2, 64'h0080},
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'd0,          -64'sd129, 1'b1, 2, 64'hff7f},
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'd0,          64'sh7fff_ffff_ffff_ffff,
			1'b1, 8, 64'h7fff_ffff_ffff_ffff},
		'{ACT_INTEGER, CLS_UNIVERSAL,   1'b0, 32'd0,          64'sh8000_0000_0000_0000,
			1'b1, 8, 64'h8000_0000_0000_0000},
		'{ACT_INTEGER, CLS_CONTEXT,     1'b1, 32'd77,         64'sh0123_4567,
			1'b0, 0, 64'h0},
		// boolean: false, and true carried only by the sign bit
		'{ACT_BOOLEAN, CLS_UNIVERSAL,   1'b0, 32'hffff_ffff,  64'sd0,  1'b1, 1, 64'h00},
		'{ACT_BOOLEAN, CLS_UNIVERSAL,   1'b0, 32'd0,          64'sh8000_0000_0000_0000,
			1'b1, 1, 64'hff},
		// subidentifier: first two-group value, widest value
		'{ACT_SUBID,   CLS_UNIVERSAL,   1'b0, 32'd128,        64'sd0,  1'b1, 2, 64'h8100},
		'{ACT_SUBID,   CLS_PRIVATE,     1'b1, 32'hffff_ffff,  64'sd0,  1'b1, 5,
			64'h8f_ff_ff_ff_7f},
		// unused action codes are taken and dropped
		'{ACT_RSVD5,   CLS_PRIVATE,     1'b1, 32'hffff_ffff,  -64'sd1, 1'b1, 0, 64'h0},
		'{ACT_RSVD7,   CLS_UNIVERSAL,   1'b0, 32'd5,          64'sd5,  1'b1, 0, 64'h0}
	};

	// ------------------------------------------------------------------------
	// byte-list model
	// ------------------------------------------------------------------------

	function automatic void owe_octet(input logic [7:0] octet, input logic fin);
		octet_beat_t b;
		b.octet = octet;
		b.fin   = fin;
		pending_octets.push_back(b);
	endfunction

	// base-128 groups, most significant first, continuation bit on all but
	// the final group; always ends the field
	function automatic void owe_base128(input logic [31:0] v);
		int         groups;
		logic [7:0] g;
		if (v <= 32'h7f)           groups = 1;
		else if (v <= 32'h3fff)    groups = 2;
		else if (v <= 32'h1f_ffff) groups = 3;
		else if (v <= 32'hfff_ffff) groups = 4;
		else                        groups = 5;
		for (int i = groups - 1; i >= 0; i--) begin
			g = {1'b0, 7'((v >> (7 * i)) & 32'h7f)};
			if (i != 0)
				g[7] = 1'b1;
			owe_octet(g, i == 0);
		end
	endfunction

	function automatic void encode_field(input logic [2:0] act, input logic [1:0] cls,
		input logic cons, input logic [31:0] uval, input logic signed [63:0] sval);
		logic [7:0] lead;
		int         n_len;
		bit         found;
		case (act)
			ACT_IDENT: begin
				lead = {cls, cons, 5'd0};
				if (uval <= 32'd30) begin
					owe_octet(lead | uval[7:0], 1'b1);
				end else begin
					owe_octet(lead | 8'h1f, 1'b0);
					owe_base128(uval);
				end
			end
			ACT_LENGTH: begin
				if (uval <= 32'h7f) begin
					owe_octet(uval[7:0], 1'b1);
				end else begin
					if (uval <= 32'hffff)        n_len = 2;
					else if (uval <= 32'hff_ffff) n_len = 3;
					else                          n_len = 4;
					owe_octet(8'h80 | 8'(n_len), 1'b0);
					for (int i = n_len - 1; i >= 0; i--)
						owe_octet(uval[8 * i +: 8], i == 0);
				end
			end
			ACT_INTEGER: begin
				// shortest two's complement form that keeps the sign
				n_len = 8;
				found = 1'b0;
				for (int k = 1; k < 8; k++) begin
					if (!found && ((sval >>> (8 * k - 1)) == 64'sd0 ||
						(sval >>> (8 * k - 1)) == -64'sd1)) begin
						n_len = k;
						found = 1'b1;
					end
				end
				for (int i = n_len - 1; i >= 0; i--)
					owe_octet(sval[8 * i +: 8], i == 0);
			end
			ACT_BOOLEAN: owe_octet((sval != 64'sd0) ? 8'hff : 8'h00, 1'b1);
			ACT_SUBID:   owe_base128(uval);
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// clock, limit
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// far beyond the slowest legal run: ~500 fields of 8 bytes, each byte
	// behind the longest pop stall, plus long push gaps
	initial begin
		#20_000_000;
		$display("timeout: %0d bytes still owed", pending_octets.size());
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// gaps: mostly none or short, now and then a long one
	// ------------------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)      return 0;
		else if (r < 88) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else             return $urandom_range(20, 60);
	endfunction

	// pop side: stalls of random length, none inside no-idle windows
	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= 1'b1;
			pop_stall = pick_gap();
		end
	end

	// ------------------------------------------------------------------------
	// accept and check, both at the rising edge
	// ------------------------------------------------------------------------

	function automatic void note_failure(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
		fail_count++;
	endfunction

	always @(posedge clk) begin
		octet_beat_t want;
		if (arst_n) begin
			// input beat taken: owe its bytes
			if (push && !full) begin
				if (action <= ACT_SUBID)
					fields_by_kind[action]++;
				else
					dropped_codes++;
				if (row_given) begin
					for (int k = row_count - 1; k >= 0; k--)
						owe_octet(row_octets[8 * k +: 8], k == 0);
				end else begin
					encode_field(action, tag_class, constructed, uvalue,
						signed_value);
				end
			end
			// output beat taken: compare with the oldest owed byte
			if (pop && !empty) begin
				octets_checked++;
				if (pending_octets.size() == 0) begin
					note_failure($sformatf("unexpected byte %02h last %0b", out_byte, last));
				end else begin
					want = pending_octets.pop_front();
					if (out_byte !== want.octet || last !== want.fin)
						note_failure($sformatf("byte exp %02h last %0b, got %02h last %0b",
							want.octet, want.fin, out_byte, last));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// push side
	// ------------------------------------------------------------------------

	// offer one field at a falling edge, return at the falling edge after
	// it was taken; push only drops when a gap follows
	task automatic offer_field(input logic [2:0] act, input logic [1:0] cls,
		input logic cons, input logic [31:0] uval, input logic signed [63:0] sval,
		input bit given, input int count, input logic [63:0] octets);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action         <= act;
		tag_class      <= cls;
		constructed    <= cons;
		uvalue         <= uval;
		signed_value   <= sval;
		row_given      = given;
		row_count      = count;
		row_octets     = octets;
		push           <= 1'b1;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// unsigned field spread over every byte-length class
	function automatic logic [31:0] random_unsigned();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 40);
			1:       return $urandom_range(100, 300);
			2:       return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// signed field: arithmetic shift of a random word hits every length
	function automatic logic signed [63:0] random_signed();
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return 64'sd0;
			1:       return -64'sd1;
			default: return v >>> $urandom_range(0, 63);
		endcase
	endfunction

	initial begin
		int         taken;
		logic [2:0] act;
		// reset held from the start, released once
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i])
			offer_field(directed_rows[i].act, directed_rows[i].cls, directed_rows[i].cons,
				directed_rows[i].uval, directed_rows[i].sval, directed_rows[i].given,
				directed_rows[i].count, directed_rows[i].octets);

		// random fields; dropped action codes do not count toward the total
		taken = 0;
		while (taken < RANDOM_FIELDS) begin
			// every fourth stretch of 32 runs with no gaps on either side
			no_idle = ((taken / 32) % 4) == 3;
			if (taken == PAUSE_AT) begin
				// hold off until the block has drained completely
				push <= 1'b0;
				wait (pending_octets.size() == 0);
				@(negedge clk);
			end
			if ($urandom_range(0, 99) < 4)
				act = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
			else
				act = 3'($urandom_range(ACT_IDENT, ACT_SUBID));
			offer_field(act, 2'($urandom), 1'($urandom), random_unsigned(), random_signed(),
				1'b0, 0, 64'h0);
			if (act <= ACT_SUBID)
				taken++;
		end
		push <= 1'b0;
		no_idle = 1'b0;

		// drain, then watch for anything stray
		wait (pending_octets.size() == 0);
		repeat (40) @(posedge clk);
		if (pending_octets.size() != 0)
			note_failure($sformatf("%0d bytes never came out", pending_octets.size()));

		$display("fields: %0d identifier, %0d length, %0d integer, %0d boolean, %0d subid",
			fields_by_kind[0], fields_by_kind[1], fields_by_kind[2], fields_by_kind[3],
			fields_by_kind[4]);
		$display("%0d unused action codes dropped, %0d output bytes compared, %0d failures",
			dropped_codes, octets_checked, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bpfe_pkg.sv
rtl/core/bpfe_front.sv
rtl/core/bpfe_fifo.sv
rtl/core/bpfe_back.sv
rtl/core/ber_primitive_field_encoder_top.sv
bench/tb_ber_primitive_field_encoder_top.sv
